// ===== rtl/sbfr_pkg.sv =====
// Shared types and constants for the serial bus frame receiver.
package sbfr_pkg;

    localparam logic [7:0]  SYNC_FIRST   = 8'h55;
    localparam logic [7:0]  SYNC_SECOND  = 8'hAA;
    localparam logic [15:0] CHECK_INVERT = 16'hFFFF;
    localparam logic [7:0]  POLL_ADDRESS = 8'h20;
    localparam logic [7:0]  POLL_COMMAND = 8'h65;
    localparam logic [7:0]  POLL_OFFSET  = 8'h00;
    localparam int          HEADER_DEPTH = 3;

    localparam logic KIND_BODY  = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_BODY  = 3'd3,
        PH_CRCLO = 3'd4,
        PH_CRCHI = 3'd5
    } phase_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [8:0]  frame_length;
        logic        checksum_ok;
        logic [15:0] computed_checksum;
        logic [15:0] received_checksum;
        logic [7:0]  device_address;
        logic        poll_slot;
        logic [31:0] frames_total;
        logic [31:0] frames_good;
        logic [31:0] frames_bad;
    } result_t;

endpackage

// ===== rtl/sbfr_deframer.sv =====
// Frame state machine: sync hunt, body, checksum check and frame counters.
module sbfr_deframer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      rx_byte,
    input  logic            bus_master_mode,
    output logic            emit,
    output sbfr_pkg::result_t result
);
    import sbfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [8:0]  length_reg, length_next;
    logic [8:0]  count_reg, count_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  check_low_reg, check_low_next;
    logic [7:0]  header_reg [HEADER_DEPTH];
    logic [7:0]  header_next [HEADER_DEPTH];
    logic [31:0] total_reg, total_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] bad_reg, bad_next;

    logic [15:0] computed;
    logic [15:0] received;
    logic        ok;
    logic        poll;

    assign computed = acc_reg ^ CHECK_INVERT;
    assign received = {rx_byte, check_low_reg};
    assign ok       = (computed == received);
    assign poll     = (header_reg[0] == POLL_ADDRESS) && (header_reg[1] == POLL_COMMAND)
                      && (header_reg[2] == POLL_OFFSET) && bus_master_mode;

    always_comb begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        check_low_next = check_low_reg;
        for (int k = 0; k < HEADER_DEPTH; k++) begin
            header_next[k] = header_reg[k];
        end
        total_next = total_reg;
        good_next  = good_reg;
        bad_next   = bad_reg;
        emit       = 1'b0;
        result     = '0;

        unique case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == SYNC_FIRST) phase_next = PH_SYNC2;
            end
            PH_SYNC2: begin
                // stay here on anything else, a repeated first sync byte too
                if (rx_byte == SYNC_SECOND) phase_next = PH_LEN;
            end
            PH_LEN: begin
                length_next = {1'b0, rx_byte} + 9'd1;
                acc_next    = {8'd0, rx_byte};
                count_next  = '0;
                phase_next  = PH_BODY;
            end
            PH_BODY: begin
                emit               = 1'b1;
                result.result_kind = KIND_BODY;
                result.data_byte   = rx_byte;
                result.byte_index  = count_reg[7:0];
                for (int k = 0; k < HEADER_DEPTH; k++) begin
                    if (count_reg == 9'(k)) header_next[k] = rx_byte;
                end
                acc_next   = acc_reg + {8'd0, rx_byte};
                count_next = count_reg + 9'd1;
                if (count_next == length_reg) phase_next = PH_CRCLO;
            end
            PH_CRCLO: begin
                check_low_next = rx_byte;
                phase_next     = PH_CRCHI;
            end
            PH_CRCHI: begin
                total_next = total_reg + 32'd1;
                if (ok) begin
                    good_next = good_reg + 32'd1;
                end else begin
                    bad_next = bad_reg + 32'd1;
                end
                emit                     = 1'b1;
                result.result_kind       = KIND_END;
                result.frame_length      = length_reg;
                result.checksum_ok       = ok;
                result.computed_checksum = computed;
                result.received_checksum = received;
                result.device_address    = header_reg[0];
                result.poll_slot         = poll;
                result.frames_total      = total_next;
                result.frames_good       = good_next;
                result.frames_bad        = bad_next;
                phase_next               = PH_HUNT;
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            length_reg    <= '0;
            count_reg     <= '0;
            acc_reg       <= '0;
            check_low_reg <= '0;
            for (int k = 0; k < HEADER_DEPTH; k++) begin
                header_reg[k] <= '0;
            end
            total_reg <= '0;
            good_reg  <= '0;
            bad_reg   <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            check_low_reg <= check_low_next;
            for (int k = 0; k < HEADER_DEPTH; k++) begin
                header_reg[k] <= header_next[k];
            end
            total_reg <= total_next;
            good_reg  <= good_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

// ===== rtl/scooter_bus_frame_receiver.sv =====
// Top level of the serial bus frame receiver: channel registers and config.
//
// Input channel s_*: one received bus byte per item (s_rx_byte).
// Result channel m_*: a body byte with its index (m_result_kind 0), or the
// frame end (m_result_kind 1) with length, checksums, status, address byte,
// poll flag and the good, bad and total frame counters. Fields that do not
// belong to the kind of result read as zero.
// Config channel cfg_*: bit 0 of cfg_data sets bus master mode; write it
// only while the receiver is idle. cfg_ready is always high.
// Path: a taken byte is held in the input register, then its result is held
// in the result register.
// Throughput: one byte per cycle while no stall on m_ready holds the flow.
// Sync, length and checksum-low bytes give no result.
// Reset: synchronous, active low; clears the frame state, the counters, the
// header bytes and bus master mode, and empties both registers.
// Stall: while m_ready is low a held result blocks the input register, and
// s_ready drops once that register is also full; nothing is dropped.
module scooter_bus_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_byte_index,
    output logic [8:0]  m_frame_length,
    output logic        m_checksum_ok,
    output logic [15:0] m_computed_checksum,
    output logic [15:0] m_received_checksum,
    output logic [7:0]  m_device_address,
    output logic        m_poll_slot,
    output logic [31:0] m_frames_total,
    output logic [31:0] m_frames_good,
    output logic [31:0] m_frames_bad,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import sbfr_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       mode_reg;

    logic       advance;
    logic       emit;
    result_t    result;

    // process the held byte when the result register can take its result
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    sbfr_deframer u_deframer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .rx_byte         (in_byte_reg),
        .bus_master_mode (mode_reg),
        .emit            (emit),
        .result          (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) begin
                out_valid_reg <= emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_byte_reg <= s_rx_byte;
        if (advance && emit) out_reg <= result;
    end

    assign m_valid             = out_valid_reg;
    assign m_result_kind       = out_reg.result_kind;
    assign m_data_byte         = out_reg.data_byte;
    assign m_byte_index        = out_reg.byte_index;
    assign m_frame_length      = out_reg.frame_length;
    assign m_checksum_ok       = out_reg.checksum_ok;
    assign m_computed_checksum = out_reg.computed_checksum;
    assign m_received_checksum = out_reg.received_checksum;
    assign m_device_address    = out_reg.device_address;
    assign m_poll_slot         = out_reg.poll_slot;
    assign m_frames_total      = out_reg.frames_total;
    assign m_frames_good       = out_reg.frames_good;
    assign m_frames_bad        = out_reg.frames_bad;

endmodule
